// ===== rtl/stb_pkg.sv =====
// shared types and codes for the software timer bank
package stb_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_TICK,
    ST_TICK_END
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  timer_index;
    logic [31:0] duration;
  } in_item_t;

  typedef struct packed {
    logic       addressed_expired;
    logic [7:0] expired_mask;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic apply;
    logic rd_en;
    logic finish;
  } cmd_t;

endpackage

// ===== rtl/software_timer_bank.sv =====
// software timer bank top level
// A bank of NUM_TIMERS timers driven by one item per start pulse: tick, start, stop or
// query. Start, stop and query keep busy high for one cycle; a tick sweeps every timer
// through the count/target ram, one entry per cycle at the ram's single read port, and
// keeps busy high through the sweep and its end state. The result is shown on result_o for
// one cycle under result_valid_o, the first cycle with busy low again, and cannot be held
// off; a new item may be started in that same cycle. The ram needs no clearing after reset.
module software_timer_bank #(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  stb_pkg::in_item_t  in_item_i,
  output stb_pkg::out_item_t result_o,
  output logic               result_valid_o
);

  localparam int IdxW = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;

  stb_pkg::cmd_t   cmd;
  logic [IdxW-1:0] rd_addr;

  stb_ctrl #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (in_item_i.opcode),
    .busy     (busy),
    .cmd_o    (cmd),
    .rd_addr_o(rd_addr)
  );

  stb_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .item_i        (in_item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule

// ===== rtl/stb_ram.sv =====
// generic single write port, single read port ram with registered read
module stb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stb_ctrl.sv =====
// controller: sequences operations and the per-timer tick sweep
module stb_ctrl #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          opcode_i,
  output logic                busy,
  output stb_pkg::cmd_t       cmd_o,
  output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] rd_addr_o
);

  localparam int IdxW = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);

  stb_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stb_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      stb_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
        if (start) begin
          cnt_d = '0;
          if (opcode_i == stb_pkg::OP_TICK) begin
            state_d = stb_pkg::ST_TICK;
          end else begin
            state_d = stb_pkg::ST_APPLY;
          end
        end
      end
      stb_pkg::ST_APPLY: begin
        cmd_o.apply  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = stb_pkg::ST_IDLE;
      end
      stb_pkg::ST_TICK: begin
        // one ram read per cycle, entry processed the cycle after
        cmd_o.rd_en = 1'b1;
        cnt_d       = IdxW'(cnt_q + 1'b1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = stb_pkg::ST_TICK_END;
        end
      end
      stb_pkg::ST_TICK_END: begin
        cmd_o.finish = 1'b1;
        state_d      = stb_pkg::ST_IDLE;
      end
      default: begin
        state_d = stb_pkg::ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o = cnt_q;

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stb_pkg::ST_TICK && cnt_q == LastIdx) |=> state_q == stb_pkg::ST_TICK_END)
    else $error("tick sweep did not end after the last timer");

  a_accept_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i != stb_pkg::OP_TICK) |=> state_q == stb_pkg::ST_APPLY)
    else $error("non-tick item not routed to apply");

endmodule

// ===== rtl/stb_dp.sv =====
// datapath: timer flags, count/target ram and result register
module stb_dp #(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stb_pkg::cmd_t       cmd_i,
  input  logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] rd_addr_i,
  input  stb_pkg::in_item_t   item_i,
  output stb_pkg::out_item_t  result_o,
  output logic                result_valid_o
);

  localparam int IdxW  = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
  localparam int MaskW = NUM_TIMERS < 8 ? NUM_TIMERS : 8;

  stb_pkg::in_item_t  item_q;
  logic [NUM_TIMERS-1:0] running_q, running_d;
  logic [NUM_TIMERS-1:0] expired_q, expired_d;
  logic                  pend_q;
  logic [IdxW-1:0]       pend_addr_q;
  stb_pkg::out_item_t    res_q, res_d;
  logic                  res_valid_q;

  logic                       idx_ok;
  logic [IdxW-1:0]            tidx;
  logic                       we;
  logic [IdxW-1:0]            waddr;
  logic [2*COUNT_WIDTH-1:0]   wdata;
  logic [2*COUNT_WIDTH-1:0]   rdata;
  logic [COUNT_WIDTH-1:0]     r_elapsed;
  logic [COUNT_WIDTH-1:0]     r_target;

  assign idx_ok    = item_q.timer_index < 8'(NUM_TIMERS);
  assign tidx      = item_q.timer_index[IdxW-1:0];
  assign r_elapsed = rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign r_target  = rdata[COUNT_WIDTH-1:0];

  // ram word is {elapsed, target}; the read data is only used while the timer is running
  stb_ram #(
    .WIDTH(2 * COUNT_WIDTH),
    .DEPTH(NUM_TIMERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  always_comb begin
    running_d = running_q;
    expired_d = expired_q;
    we        = 1'b0;
    waddr     = tidx;
    wdata     = {{COUNT_WIDTH{1'b0}}, item_q.duration[COUNT_WIDTH-1:0]};
    if (cmd_i.apply && idx_ok) begin
      case (item_q.opcode)
        stb_pkg::OP_START: begin
          running_d[tidx] = 1'b1;
          expired_d[tidx] = 1'b0;
          we              = 1'b1;
        end
        stb_pkg::OP_STOP: begin
          running_d[tidx] = 1'b0;
          expired_d[tidx] = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (pend_q) begin
      if (running_q[pend_addr_q]) begin
        if (r_target <= r_elapsed) begin
          expired_d[pend_addr_q] = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = pend_addr_q;
          wdata = {COUNT_WIDTH'(r_elapsed + 1'b1), r_target};
        end
      end else begin
        expired_d[pend_addr_q] = 1'b0;
      end
    end
  end

  always_comb begin
    res_d.addressed_expired = (item_q.opcode != stb_pkg::OP_TICK) && idx_ok
                              && expired_d[tidx];
    res_d.expired_mask      = 8'(expired_d[MaskW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      expired_q   <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      expired_q   <= expired_d;
      pend_q      <= cmd_i.rd_en;
      res_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.rd_en) begin
      pend_addr_q <= rd_addr_i;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.apply, pend_q, cmd_i.capture}))
    else $error("operation apply overlaps tick processing or capture");

  a_expired_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (expired_q & ~running_q) == '0)
    else $error("idle timer shows expired");

endmodule

// ===== verif/stb_tb_pkg.sv =====
// command predictor and result checker for the timer bank testbench
`timescale 1ns / 100ps

package stb_tb_pkg;

  localparam int SHADOW_TIMERS = 8;

  class timer_shadow;
    bit        running [SHADOW_TIMERS];
    bit        expired [SHADOW_TIMERS];
    bit [31:0] elapsed [SHADOW_TIMERS];
    bit [31:0] target  [SHADOW_TIMERS];
    stb_pkg::out_item_t pending_flags [$];
    int unsigned failures;

    // advance the shadow timers by one command and queue the flags it should report
    function void apply_command(stb_pkg::in_item_t cmd);
      stb_pkg::out_item_t flags;
      bit        in_range;
      int        t;
      in_range = cmd.timer_index < SHADOW_TIMERS;
      t        = in_range ? int'(cmd.timer_index) : 0;
      case (stb_pkg::opcode_e'(cmd.opcode))
        stb_pkg::OP_TICK: begin
          for (int i = 0; i < SHADOW_TIMERS; i++) begin
            if (running[i]) begin
              // count holds once it reaches the target
              if (target[i] <= elapsed[i]) expired[i] = 1'b1;
              else elapsed[i] = elapsed[i] + 32'd1;
            end else begin
              expired[i] = 1'b0;
              elapsed[i] = '0;
            end
          end
        end
        stb_pkg::OP_START: begin
          if (in_range) begin
            elapsed[t] = '0;
            target[t]  = cmd.duration;
            running[t] = 1'b1;
            expired[t] = 1'b0;
          end
        end
        stb_pkg::OP_STOP: begin
          if (in_range) begin
            running[t] = 1'b0;
            elapsed[t] = '0;
            expired[t] = 1'b0;
          end
        end
        default: ;
      endcase
      flags.addressed_expired =
          (stb_pkg::opcode_e'(cmd.opcode) != stb_pkg::OP_TICK && in_range) ?
          expired[t] : 1'b0;
      for (int i = 0; i < 8; i++)
        flags.expired_mask[i] = (i < SHADOW_TIMERS) ? expired[i] : 1'b0;
      pending_flags.push_back(flags);
    endfunction

    function void compare_flags(stb_pkg::out_item_t got);
      stb_pkg::out_item_t want;
      if (pending_flags.size() == 0) begin
        $error("result with no command outstanding: %h", got);
        failures++;
        return;
      end
      want = pending_flags.pop_front();
      if (got.addressed_expired !== want.addressed_expired) begin
        $error("addressed_expired: expected %b, got %b",
               want.addressed_expired, got.addressed_expired);
        failures++;
      end
      if (got.expired_mask !== want.expired_mask) begin
        $error("expired_mask: expected %b, got %b", want.expired_mask, got.expired_mask);
        failures++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_flags.size();
    endfunction
  endclass

endpackage

// ===== verif/software_timer_bank_tb.sv =====
// testbench for the software timer bank: directed and random commands against a shadow model
`timescale 1ns / 100ps

module software_timer_bank_tb;

  localparam int RANDOM_COMMANDS = 1600;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  stb_pkg::in_item_t  in_item_i      = '0;
  logic               busy;
  stb_pkg::out_item_t result_o;
  logic               result_valid_o;

  stb_tb_pkg::timer_shadow shadow = new();

  software_timer_bank #(
    .NUM_TIMERS (stb_tb_pkg::SHADOW_TIMERS),
    .COUNT_WIDTH(32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_item_i     (in_item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // values seen here are the ones before this edge's updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) shadow.apply_command(in_item_i);
      if (result_valid_o) shadow.compare_flags(result_o);
    end
  end

  function automatic stb_pkg::in_item_t make_command(stb_pkg::opcode_e op,
                                                     logic [7:0] idx, logic [31:0] dur);
    stb_pkg::in_item_t cmd;
    cmd.opcode      = op;
    cmd.timer_index = idx;
    cmd.duration    = dur;
    return cmd;
  endfunction

  function automatic stb_pkg::in_item_t random_command();
    stb_pkg::opcode_e op;
    logic [7:0]  idx;
    logic [31:0] dur;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = stb_pkg::OP_TICK;
    else if (pick < 62) op = stb_pkg::OP_START;
    else if (pick < 72) op = stb_pkg::OP_STOP;
    else op = stb_pkg::OP_QUERY;
    idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    // mostly short durations so that timers actually run out
    if (pick < 80) dur = $urandom_range(0, 12);
    else if (pick < 95) dur = $urandom_range(0, 60);
    else dur = $urandom;
    return make_command(op, idx, dur);
  endfunction

  // holds the command on the bus until an edge takes it
  task automatic send_command(stb_pkg::in_item_t cmd);
    start     <= 1'b1;
    in_item_i <= cmd;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(make_command(stb_pkg::OP_QUERY, 8'd0, 32'd0));
    send_command(make_command(stb_pkg::OP_START, 8'd0, 32'd0));
    send_command(make_command(stb_pkg::OP_TICK, 8'hff, 32'hffff_ffff));
    send_command(make_command(stb_pkg::OP_QUERY, 8'd0, 32'd0));
    send_command(make_command(stb_pkg::OP_START, 8'd7, 32'hffff_ffff));
    send_command(make_command(stb_pkg::OP_START, 8'hff, 32'd1));
    send_command(make_command(stb_pkg::OP_START, 8'd8, 32'd0));
    send_command(make_command(stb_pkg::OP_STOP, 8'd8, 32'd0));
    send_command(make_command(stb_pkg::OP_QUERY, 8'hff, 32'd0));
    send_command(make_command(stb_pkg::OP_START, 8'd3, 32'd2));
    send_command(make_command(stb_pkg::OP_TICK, 8'd3, 32'd0));
    send_command(make_command(stb_pkg::OP_TICK, 8'd0, 32'd0));
    send_command(make_command(stb_pkg::OP_QUERY, 8'd3, 32'd0));
    send_command(make_command(stb_pkg::OP_TICK, 8'd0, 32'd0));
    send_command(make_command(stb_pkg::OP_QUERY, 8'd3, 32'd0));
    send_command(make_command(stb_pkg::OP_STOP, 8'd3, 32'd0));
    send_command(make_command(stb_pkg::OP_QUERY, 8'd3, 32'd0));
    send_command(make_command(stb_pkg::OP_START, 8'd1, 32'd1));
    send_command(make_command(stb_pkg::OP_TICK, 8'd0, 32'd0));
    send_command(make_command(stb_pkg::OP_TICK, 8'd0, 32'd0));
    send_command(make_command(stb_pkg::OP_QUERY, 8'd1, 32'd0));
    send_command(make_command(stb_pkg::OP_QUERY, 8'd7, 32'd0));
    send_command(make_command(stb_pkg::OP_STOP, 8'd0, 32'd0));
    send_command(make_command(stb_pkg::OP_STOP, 8'd7, 32'd0));
    send_command(make_command(stb_pkg::OP_TICK, 8'd0, 32'd0));

    sent = 0;
    while (sent < RANDOM_COMMANDS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_command(random_command());
      sent += burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    pause_sender(0);

    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (stb_tb_pkg::SHADOW_TIMERS + 12) @(posedge clk_i);
    if (shadow.failures == 0) begin
      $display("software_timer_bank: match");
    end else begin
      $display("software_timer_bank: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("software_timer_bank: mismatch");
    $finish;
  end

endmodule
